@@ hw/rtl/c8fb_pkg.sv @@
// Package for the monochrome frame store with XOR sprite drawing.
// Holds stream field widths, command and result codes, and the placement struct.
// No dependencies; imported by c8fb_place, the top level and the checker.
`default_nettype none

package c8fb_pkg;

   localparam int unsigned FRAME_WIDTH_DEF  = 64;
   localparam int unsigned FRAME_HEIGHT_DEF = 32;

   localparam int unsigned ROW_BITS    = 64;
   localparam int unsigned SPRITE_BITS = 8;
   localparam int unsigned ROW_IDX_W   = 7;

   localparam int unsigned CMD_W        = 2;
   localparam int unsigned POS_X_W      = 6;
   localparam int unsigned POS_Y_W      = 5;
   localparam int unsigned ROW_OFFSET_W = 4;

   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 136;
   localparam int unsigned RSP_USER_W = 1;

   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DRAW   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RENDER = 2'd2;

   localparam logic KIND_COLLISION = 1'b0;
   localparam logic KIND_ROW       = 1'b1;

   // Where one sprite row lands: first frame row and optional spill row.
   // Masks use the 64-bit row form, column 0 in bit 63.
   typedef struct packed {
      logic [ROW_IDX_W-1:0] row_a;
      logic                 ok_a;
      logic                 ok_b;
      logic [ROW_BITS-1:0]  mask_a;
      logic [ROW_BITS-1:0]  mask_b;
   } place_type;

endpackage

`default_nettype wire

@@ hw/rtl/c8fb_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module c8fb_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/c8fb_place.sv @@
// Sprite row placement: frame row(s) and pixel masks for one draw item.
// Depends on c8fb_pkg.
`default_nettype none

module c8fb_place #(
   parameter int unsigned FRAME_WIDTH  = c8fb_pkg::FRAME_WIDTH_DEF,
   parameter int unsigned FRAME_HEIGHT = c8fb_pkg::FRAME_HEIGHT_DEF
) (
   input  wire logic [c8fb_pkg::POS_X_W-1:0]      pos_x,
   input  wire logic [c8fb_pkg::POS_Y_W-1:0]      pos_y,
   input  wire logic [c8fb_pkg::ROW_OFFSET_W-1:0] row_offset,
   input  wire logic [c8fb_pkg::SPRITE_BITS-1:0]  sprite_row,
   output c8fb_pkg::place_type                    place
);

   import c8fb_pkg::*;

   localparam int unsigned SPAN_W = 2 * FRAME_WIDTH;
   localparam logic [ROW_IDX_W-1:0] WIDTH_R  = ROW_IDX_W'(FRAME_WIDTH);
   localparam logic [ROW_IDX_W-1:0] HEIGHT_R = ROW_IDX_W'(FRAME_HEIGHT);

   logic [ROW_IDX_W-1:0]   col;
   logic [ROW_IDX_W-1:0]   quot;
   logic [ROW_IDX_W-1:0]   row_a;
   logic [ROW_IDX_W-1:0]   row_b;
   logic [SPAN_W-1:0]      span;
   logic [FRAME_WIDTH-1:0] mask_a_w;
   logic [FRAME_WIDTH-1:0] mask_b_w;

   always_comb begin
      // pos_x may exceed a narrow frame: reduce it, carrying whole rows
      col  = ROW_IDX_W'(pos_x);
      quot = '0;
      for (int i = 0; i < SPRITE_BITS; i++) begin
         if (col >= WIDTH_R) begin
            col  = col - WIDTH_R;
            quot = quot + ROW_IDX_W'(1);
         end
      end
      row_a = ROW_IDX_W'(pos_y) + ROW_IDX_W'(row_offset) + quot;
      row_b = row_a + ROW_IDX_W'(1);

      span     = (SPAN_W'(sprite_row) << (SPAN_W - SPRITE_BITS)) >> col;
      mask_a_w = span[SPAN_W-1 -: FRAME_WIDTH];
      mask_b_w = span[FRAME_WIDTH-1:0];

      place.row_a  = row_a;
      place.ok_a   = (row_a < HEIGHT_R);
      place.ok_b   = (row_b < HEIGHT_R) && (|mask_b_w);
      place.mask_a = ROW_BITS'(mask_a_w) << (ROW_BITS - FRAME_WIDTH);
      place.mask_b = ROW_BITS'(mask_b_w) << (ROW_BITS - FRAME_WIDTH);
   end

endmodule

`default_nettype wire

@@ hw/rtl/chip8_framebuffer_xor_draw_top.sv @@
// Top level of the monochrome XOR-draw frame store: sequencer, valid bits, output register.
// Depends on c8fb_pkg, c8fb_place and c8fb_ram (frame memory and shown-row memory).
//
// Frame rows and last-shown rows each live in a one-read, one-write synchronous RAM.
// A clear command drops per-row valid flops, so no clearing pass is needed after
// reset or clear; an unused command changes nothing. A render reads the frame and
// shown rows, then loads the result and writes the shown row back. A draw item handles
// its first frame row, then the spill row if any, since each touched row is a
// read-modify-write through the single frame write port. A result item waits in an
// output register; a further result is held back only while that register is full.
`default_nettype none

module chip8_framebuffer_xor_draw_top #(
   parameter int unsigned FRAME_WIDTH  = c8fb_pkg::FRAME_WIDTH_DEF,
   parameter int unsigned FRAME_HEIGHT = c8fb_pkg::FRAME_HEIGHT_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // pos_x[5:0], pos_y[10:6], row_offset[14:11], sprite_row[22:15], zero pad
   input  wire logic [c8fb_pkg::REQ_DATA_W-1:0]   req_tdata,
   // command[1:0]
   input  wire logic [c8fb_pkg::CMD_W-1:0]        req_tuser,
   input  wire logic                              req_tlast,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // collision[0], row_index[5:1], row_pixels[69:6], changed_mask[133:70], zero pad
   output logic      [c8fb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // result_kind[0]
   output logic      [c8fb_pkg::RSP_USER_W-1:0]   rsp_tuser
);

   import c8fb_pkg::*;

   localparam int unsigned AW = $clog2(FRAME_HEIGHT);
   localparam logic [ROW_IDX_W-1:0] HEIGHT_R = ROW_IDX_W'(FRAME_HEIGHT);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DRAW_A = 2'd1;
   localparam logic [1:0] S_DRAW_B = 2'd2;
   localparam logic [1:0] S_RENDER = 2'd3;

   logic [1:0]              state_ff, state_in;
   place_type               place_now;
   place_type               place_ff, place_in;
   logic                    last_ff, last_in;
   logic                    acc_ff, acc_in;
   logic [POS_Y_W-1:0]      py_ff, py_in;
   logic                    rok_ff, rok_in;
   logic [FRAME_HEIGHT-1:0] fvalid_ff, fvalid_in;
   logic [FRAME_HEIGHT-1:0] svalid_ff, svalid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                    rsp_kind_ff, rsp_kind_in;

   logic [POS_X_W-1:0]      pos_x;
   logic [POS_Y_W-1:0]      pos_y;
   logic [ROW_OFFSET_W-1:0] row_offset;
   logic [SPRITE_BITS-1:0]  sprite_row;

   logic                    req_fire;
   logic                    adv;
   logic [ROW_IDX_W-1:0]    py_wide, py_ff_wide, row_b_wide;
   logic                    py_ok;
   logic [AW-1:0]           py_addr, py_addr_ff, addr_a, addr_b, cur_addr;
   logic                    cur_ok;
   logic [FRAME_WIDTH-1:0]  cur_mask, old_w, new_w, pix_w, changed_w;
   logic                    hit, col;
   logic                    final_step, emit_draw, step_go, render_go;

   logic                    f_we, f_re, s_we, s_re;
   logic [AW-1:0]           f_raddr;
   logic [FRAME_WIDTH-1:0]  f_q, s_q;

   assign pos_x      = req_tdata[5:0];
   assign pos_y      = req_tdata[10:6];
   assign row_offset = req_tdata[14:11];
   assign sprite_row = req_tdata[22:15];

   c8fb_place #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
   ) u_place (
      .pos_x      (pos_x),
      .pos_y      (pos_y),
      .row_offset (row_offset),
      .sprite_row (sprite_row),
      .place      (place_now)
   );

   c8fb_ram #(
      .WIDTH (FRAME_WIDTH),
      .DEPTH (FRAME_HEIGHT)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (f_we),
      .wr_addr (cur_addr),
      .wr_data (new_w),
      .rd_en   (f_re),
      .rd_addr (f_raddr),
      .rd_data (f_q)
   );

   c8fb_ram #(
      .WIDTH (FRAME_WIDTH),
      .DEPTH (FRAME_HEIGHT)
   ) u_shown_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (py_addr_ff),
      .wr_data (pix_w),
      .rd_en   (s_re),
      .rd_addr (py_addr),
      .rd_data (s_q)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign adv        = !rsp_valid_ff || rsp_tready;

   assign py_wide    = ROW_IDX_W'(pos_y);
   assign py_ok      = (py_wide < HEIGHT_R);
   assign py_addr    = py_wide[AW-1:0];
   assign py_ff_wide = ROW_IDX_W'(py_ff);
   assign py_addr_ff = py_ff_wide[AW-1:0];
   assign addr_a     = place_ff.row_a[AW-1:0];
   assign row_b_wide = place_ff.row_a + ROW_IDX_W'(1);
   assign addr_b     = row_b_wide[AW-1:0];

   always_comb begin
      if (state_ff == S_DRAW_B) begin
         cur_addr = addr_b;
         cur_ok   = place_ff.ok_b;
         cur_mask = place_ff.mask_b[ROW_BITS-1 -: FRAME_WIDTH];
      end else begin
         cur_addr = addr_a;
         cur_ok   = place_ff.ok_a;
         cur_mask = place_ff.mask_a[ROW_BITS-1 -: FRAME_WIDTH];
      end
      old_w = (cur_ok && fvalid_ff[cur_addr]) ? f_q : '0;
      new_w = old_w ^ cur_mask;
      hit   = cur_ok && (|(old_w & cur_mask));
      col   = acc_ff || hit;

      pix_w     = (rok_ff && fvalid_ff[py_addr_ff]) ? f_q : '0;
      changed_w = (rok_ff && svalid_ff[py_addr_ff]) ? (pix_w ^ s_q) : '1;

      final_step = ((state_ff == S_DRAW_A) && !place_ff.ok_b) || (state_ff == S_DRAW_B);
      emit_draw  = final_step && last_ff;
      step_go    = (state_ff inside {S_DRAW_A, S_DRAW_B}) && (!emit_draw || adv);
      render_go  = (state_ff == S_RENDER) && adv;

      f_we = step_go && cur_ok;
      f_re = (req_fire && (req_tuser == CMD_DRAW) && place_now.ok_a)
          || (req_fire && (req_tuser == CMD_RENDER) && py_ok)
          || ((state_ff == S_DRAW_A) && place_ff.ok_b && step_go);
      f_raddr = req_fire ? ((req_tuser == CMD_DRAW) ? place_now.row_a[AW-1:0] : py_addr)
                         : addr_b;
      s_re = req_fire && (req_tuser == CMD_RENDER) && py_ok;
      s_we = render_go && rok_ff;
   end

   always_comb begin
      state_in     = state_ff;
      place_in     = place_ff;
      last_in      = last_ff;
      acc_in       = acc_ff;
      py_in        = py_ff;
      rok_in       = rok_ff;
      fvalid_in    = fvalid_ff;
      svalid_in    = svalid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;

      if (f_we) begin
         fvalid_in[cur_addr] = 1'b1;
      end
      if (s_we) begin
         svalid_in[py_addr_ff] = 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               place_in = place_now;
               last_in  = req_tlast;
               py_in    = pos_y;
               rok_in   = py_ok;
               case (req_tuser)
                  CMD_CLEAR: begin
                     fvalid_in = '0;
                     svalid_in = '0;
                  end
                  CMD_DRAW:   state_in = S_DRAW_A;
                  CMD_RENDER: state_in = S_RENDER;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_DRAW_A, S_DRAW_B: begin
            if (step_go) begin
               if (!final_step) begin
                  acc_in   = col;
                  state_in = S_DRAW_B;
               end else begin
                  acc_in   = last_ff ? 1'b0 : col;
                  state_in = S_IDLE;
                  if (last_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_COLLISION;
                     rsp_data_in  = RSP_DATA_W'(col);
                  end
               end
            end
         end
         S_RENDER: begin
            if (render_go) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ROW;
               rsp_data_in  = '0;
               rsp_data_in[5:1] = py_ff;
               if (rok_ff) begin
                  rsp_data_in[69:6]   = ROW_BITS'(pix_w) << (ROW_BITS - FRAME_WIDTH);
                  rsp_data_in[133:70] = ROW_BITS'(changed_w) << (ROW_BITS - FRAME_WIDTH);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= 1'b0;
         fvalid_ff    <= '0;
         svalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         fvalid_ff    <= fvalid_in;
         svalid_ff    <= svalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      place_ff    <= place_in;
      last_ff     <= last_in;
      py_ff       <= py_in;
      rok_ff      <= rok_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

endmodule

`default_nettype wire

@@ hw/rtl/c8fb_checker.sv @@
// Port-level checker for the XOR-draw frame store, bound to the top level.
// Depends on c8fb_pkg and chip8_framebuffer_xor_draw_top.
`default_nettype none

module c8fb_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic [c8fb_pkg::CMD_W-1:0]        req_tuser,
   input wire logic                              req_tlast,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [c8fb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input wire logic [c8fb_pkg::RSP_USER_W-1:0]   rsp_tuser
);

   import c8fb_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   a_collision_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_COLLISION) |-> (rsp_tdata[RSP_DATA_W-1:1] == '0))
      else $error("collision item carries row data");

   a_render_no_collision: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_ROW) |-> !rsp_tdata[0])
      else $error("render item flags a collision");

   a_draw_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == CMD_DRAW) && !req_tlast |=> !req_tready)
      else $error("draw item did not occupy the frame memory");

endmodule

bind chip8_framebuffer_xor_draw_top c8fb_checker u_checker (.*);

`default_nettype wire
